// ----- sv/glyph_bitmap_to_rgba4444_blit_assert.svh -----
// assertion macros for the glyph blitter
`ifndef GLYPH_BITMAP_TO_RGBA4444_BLIT_ASSERT_SVH
`define GLYPH_BITMAP_TO_RGBA4444_BLIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define GBB_ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define GBB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define GBB_ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)
`define GBB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- sv/gbb_pkg.sv -----
// shared types, constants and helpers of the glyph blitter
`default_nettype none

package gbb_pkg;

    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 16;
    localparam int ADDR_W      = 22;
    localparam int PIX_W       = 16;
    localparam int CMP_W       = 16;
    localparam int RUN_W       = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [PIX_W-1:0] COLOR_RGB_MASK = 16'hFFF0;
    localparam logic [PIX_W-1:0] PIXEL_CLEAR    = 16'h0000;
    localparam logic [RUN_W-1:0] MONO_RUN       = 4'd8;
    localparam logic [RUN_W-1:0] GRAY_RUN       = 4'd1;
    localparam logic [RUN_W-1:0] NO_RUN         = 4'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X         = 4'd0,
        CFG_ORIGIN_Y         = 4'd1,
        CFG_DEST_WIDTH       = 4'd2,
        CFG_DEST_HEIGHT      = 4'd3,
        CFG_SOURCE_ROW_BYTES = 4'd4,
        CFG_SOURCE_ROWS      = 4'd5,
        CFG_MONO_MODE        = 4'd6,
        CFG_GLYPH_COLOR      = 4'd7
    } cfg_index_t;

    typedef struct packed {
        logic [10:0] origin_x;
        logic [10:0] origin_y;
        logic [11:0] dest_width;
        logic [11:0] dest_height;
        logic [8:0]  source_row_bytes;
        logic [8:0]  source_rows;
        logic        mono_mode;
        logic [15:0] glyph_color;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        origin_x:         11'd0,
        origin_y:         11'd0,
        dest_width:       12'd2048,
        dest_height:      12'd2048,
        source_row_bytes: 9'd1,
        source_rows:      9'd1,
        mono_mode:        1'b0,
        glyph_color:      16'h0000
    };

    // one classified source byte: first write address, value, bits, mono flag and write count
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  value;
        logic [7:0]        bits;
        logic              mono;
        logic [RUN_W-1:0]  count;
    } blit_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // coverage * 15 / 255 == coverage / 17, done as a reciprocal multiply
    function automatic logic [3:0] gray_alpha(input logic [7:0] coverage);
        logic [15:0] prod;
        prod = 16'(coverage) * 16'd241;
        return prod[15:12];
    endfunction

endpackage

`default_nettype wire

// ----- sv/glyph_bitmap_to_rgba4444_blit.sv -----
// top level of the glyph bitmap to rgba4444 blitter
//
// Glyph bitmap bytes enter on the s_ channel in raster order and leave as clipped
// RGBA4444 pixel writes on the m_ channel, one write per transaction. A gray byte
// makes at most one write; a mono byte makes up to eight writes, one per cycle
// while m_ready does not hold the output, so a stream of unclipped mono bytes is
// limited by the single result port. A byte passes the front hold register, the
// queue, the back-end run registers and the output register to its first write,
// and the four-entry queue lets bytes keep arriving while a run is written out.
// The user must write registers through cfg_we/cfg_index/cfg_wdata only while no
// transaction is in flight; the block does not enforce it. Indexes above the glyph
// color register are ignored. Nothing needs clearing after reset.
`default_nettype none

`include "glyph_bitmap_to_rgba4444_blit_assert.svh"

module glyph_bitmap_to_rgba4444_blit #(
    parameter int MAX_DEST_WIDTH  = 2048,
    parameter int MAX_DEST_HEIGHT = 2048,
    parameter int MAX_GLYPH_DIM   = 256
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_we,
    input  wire logic [gbb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [gbb_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [7:0]                        s_source_byte,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [gbb_pkg::ADDR_W-1:0]             m_pixel_address,
    output logic [gbb_pkg::PIX_W-1:0]              m_pixel_value,
    output logic                                   m_last_of_run
);

    gbb_pkg::cfg_t          cfg_reg, cfg_next;
    gbb_pkg::queue_status_t q_status;
    gbb_pkg::blit_cmd_t     q_push_cmd;
    gbb_pkg::blit_cmd_t     q_pop_cmd;
    logic                   q_push;
    logic                   q_pop;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                gbb_pkg::CFG_ORIGIN_X:         cfg_next.origin_x = cfg_wdata[10:0];
                gbb_pkg::CFG_ORIGIN_Y:         cfg_next.origin_y = cfg_wdata[10:0];
                gbb_pkg::CFG_DEST_WIDTH:       cfg_next.dest_width = cfg_wdata[11:0];
                gbb_pkg::CFG_DEST_HEIGHT:      cfg_next.dest_height = cfg_wdata[11:0];
                gbb_pkg::CFG_SOURCE_ROW_BYTES: cfg_next.source_row_bytes = cfg_wdata[8:0];
                gbb_pkg::CFG_SOURCE_ROWS:      cfg_next.source_rows = cfg_wdata[8:0];
                gbb_pkg::CFG_MONO_MODE:        cfg_next.mono_mode = cfg_wdata[0];
                gbb_pkg::CFG_GLYPH_COLOR:      cfg_next.glyph_color = cfg_wdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= gbb_pkg::CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    gbb_front #(
        .MAX_DEST_WIDTH  (MAX_DEST_WIDTH),
        .MAX_DEST_HEIGHT (MAX_DEST_HEIGHT),
        .MAX_GLYPH_DIM   (MAX_GLYPH_DIM)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_source_byte (s_source_byte),
        .q_status      (q_status),
        .q_push        (q_push),
        .q_cmd         (q_push_cmd)
    );

    gbb_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_push_cmd),
        .pop      (q_pop),
        .pop_cmd  (q_pop_cmd),
        .status   (q_status)
    );

    gbb_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_status        (q_status),
        .q_pop           (q_pop),
        .q_cmd           (q_pop_cmd),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pixel_address (m_pixel_address),
        .m_pixel_value   (m_pixel_value),
        .m_last_of_run   (m_last_of_run)
    );

    `GBB_ASSERT_ALWAYS(a_no_queue_overflow, aclk, aresetn, !(q_push && q_status.full), "queue written while full")
    `GBB_ASSERT_ALWAYS(a_no_queue_underflow, aclk, aresetn, !(q_pop && q_status.empty), "queue read while empty")
    `GBB_ASSERT_NEXT(a_run_unbroken, aclk, aresetn, m_valid && m_ready && !m_last_of_run, m_valid, "gap inside a pixel run")

endmodule

`default_nettype wire

// ----- sv/gbb_front.sv -----
// front end: accepts bitmap bytes, tracks raster position, clips and classifies
`default_nettype none

module gbb_front #(
    parameter int MAX_DEST_WIDTH  = 2048,
    parameter int MAX_DEST_HEIGHT = 2048,
    parameter int MAX_GLYPH_DIM   = 256
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire gbb_pkg::cfg_t         cfg,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [7:0]            s_source_byte,
    input  wire gbb_pkg::queue_status_t q_status,
    output logic                       q_push,
    output gbb_pkg::blit_cmd_t         q_cmd
);

    localparam int POS_W = $clog2(MAX_GLYPH_DIM);
    localparam int DIM_W = POS_W + 1;
    localparam int AW    = gbb_pkg::ADDR_W;
    localparam int CW    = gbb_pkg::CMP_W;

    logic [11:0]      eff_width;
    logic [11:0]      eff_height;
    logic [DIM_W-1:0] stride;
    logic [DIM_W-1:0] rows;

    logic [POS_W-1:0] col_reg, col_next;
    logic [POS_W-1:0] row_reg, row_next;
    logic             col_last, row_last;
    logic             accept;

    logic             a_valid_reg, a_valid_next;
    logic [7:0]       a_byte_reg;
    logic [3:0]       a_alpha_reg;
    logic [POS_W-1:0] a_col_reg;
    logic [POS_W-1:0] a_row_reg;
    logic             a_start_reg;
    logic             a_row_end_reg;

    logic [AW:0]      origin_prod;
    logic [AW-1:0]    orig_base_reg;
    logic [AW-1:0]    row_base_reg, row_base_next;

    logic [AW-1:0]    base;
    logic [CW-1:0]    dest_row;
    logic             row_ok;
    logic [CW-1:0]    gray_col;
    logic [POS_W+2:0] mono_off;
    logic [CW-1:0]    mono_col;
    logic [CW-1:0]    mono_room;
    logic [gbb_pkg::RUN_W-1:0] mono_count;
    logic [gbb_pkg::RUN_W-1:0] gray_count;
    logic [AW-1:0]    pix_off;

    always_comb begin
        eff_width  = (32'(cfg.dest_width) > MAX_DEST_WIDTH) ?
                     12'(MAX_DEST_WIDTH) : cfg.dest_width;
        eff_height = (32'(cfg.dest_height) > MAX_DEST_HEIGHT) ?
                     12'(MAX_DEST_HEIGHT) : cfg.dest_height;
        if (cfg.source_row_bytes == '0) begin
            stride = DIM_W'(1);
        end else if (32'(cfg.source_row_bytes) > MAX_GLYPH_DIM) begin
            stride = DIM_W'(MAX_GLYPH_DIM);
        end else begin
            stride = DIM_W'(cfg.source_row_bytes);
        end
        if (cfg.source_rows == '0) begin
            rows = DIM_W'(1);
        end else if (32'(cfg.source_rows) > MAX_GLYPH_DIM) begin
            rows = DIM_W'(MAX_GLYPH_DIM);
        end else begin
            rows = DIM_W'(cfg.source_rows);
        end
    end

    // raster position of the byte being accepted
    assign col_last = (DIM_W'(col_reg) + DIM_W'(1)) >= stride;
    assign row_last = (DIM_W'(row_reg) + DIM_W'(1)) >= rows;
    assign accept   = s_valid && s_ready;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (col_last) begin
                col_next = '0;
                row_next = row_last ? '0 : row_reg + POS_W'(1);
            end else begin
                col_next = col_reg + POS_W'(1);
            end
        end
    end

    assign q_push       = a_valid_reg && !q_status.full;
    assign s_ready      = !a_valid_reg || q_push;
    assign a_valid_next = accept ? 1'b1 : (q_push ? 1'b0 : a_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            a_valid_reg  <= 1'b0;
            row_base_reg <= '0;
        end else begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            a_valid_reg  <= a_valid_next;
            row_base_reg <= row_base_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            a_byte_reg    <= s_source_byte;
            a_alpha_reg   <= gbb_pkg::gray_alpha(s_source_byte);
            a_col_reg     <= col_reg;
            a_row_reg     <= row_reg;
            a_start_reg   <= (col_reg == '0) && (row_reg == '0);
            a_row_end_reg <= col_last;
        end
        orig_base_reg <= AW'(origin_prod + (AW + 1)'(cfg.origin_x));
    end

    // glyph origin address, kept current from the registers
    assign origin_prod = (AW + 1)'(cfg.origin_y) * (AW + 1)'(eff_width);

    // classification of the held byte
    always_comb begin
        base      = a_start_reg ? orig_base_reg : row_base_reg;
        dest_row  = CW'(cfg.origin_y) + CW'(a_row_reg);
        row_ok    = dest_row < CW'(eff_height);
        gray_col  = CW'(cfg.origin_x) + CW'(a_col_reg);
        mono_off  = {a_col_reg, 3'b000};
        mono_col  = CW'(cfg.origin_x) + CW'(mono_off);
        mono_room = CW'(eff_width) - mono_col;

        if (!row_ok || (mono_col >= CW'(eff_width))) begin
            mono_count = gbb_pkg::NO_RUN;
        end else if (mono_room >= CW'(gbb_pkg::MONO_RUN)) begin
            mono_count = gbb_pkg::MONO_RUN;
        end else begin
            mono_count = mono_room[gbb_pkg::RUN_W-1:0];
        end

        if (row_ok && (a_byte_reg != 8'h00) && (gray_col < CW'(eff_width))) begin
            gray_count = gbb_pkg::GRAY_RUN;
        end else begin
            gray_count = gbb_pkg::NO_RUN;
        end

        pix_off = cfg.mono_mode ? AW'(mono_off) : AW'(a_col_reg);

        q_cmd.addr  = base + pix_off;
        q_cmd.value = cfg.mono_mode ? cfg.glyph_color :
                      ((cfg.glyph_color & gbb_pkg::COLOR_RGB_MASK) |
                       gbb_pkg::PIX_W'(a_alpha_reg));
        q_cmd.bits  = a_byte_reg;
        q_cmd.mono  = cfg.mono_mode;
        q_cmd.count = cfg.mono_mode ? mono_count : gray_count;

        row_base_next = row_base_reg;
        if (q_push) begin
            row_base_next = a_row_end_reg ? base + AW'(eff_width) : base;
        end
    end

endmodule

`default_nettype wire

// ----- sv/gbb_fifo.sv -----
// short command queue between the front and back ends
`default_nettype none

module gbb_fifo (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   push,
    input  wire gbb_pkg::blit_cmd_t     push_cmd,
    input  wire logic                   pop,
    output gbb_pkg::blit_cmd_t          pop_cmd,
    output gbb_pkg::queue_status_t      status
);

    localparam int PW = gbb_pkg::QPTR_W;

    gbb_pkg::blit_cmd_t mem_reg [gbb_pkg::QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW:0]   count_reg, count_next;

    assign status.full  = count_reg == (PW + 1)'(gbb_pkg::QUEUE_DEPTH);
    assign status.empty = count_reg == '0;
    assign pop_cmd      = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (PW + 1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (PW + 1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ----- sv/gbb_back.sv -----
// back end: expands each command into pixel write transactions
`default_nettype none

module gbb_back (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire gbb_pkg::queue_status_t   q_status,
    output logic                          q_pop,
    input  wire gbb_pkg::blit_cmd_t       q_cmd,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic [gbb_pkg::ADDR_W-1:0]    m_pixel_address,
    output logic [gbb_pkg::PIX_W-1:0]     m_pixel_value,
    output logic                          m_last_of_run
);

    localparam int AW = gbb_pkg::ADDR_W;
    localparam int RW = gbb_pkg::RUN_W;

    logic [RW-1:0]               cnt_reg, cnt_next;
    logic [AW-1:0]               addr_reg;
    logic [gbb_pkg::PIX_W-1:0]   value_reg;
    logic [7:0]                  bits_reg;
    logic                        mono_reg;

    logic                        m_valid_reg, m_valid_next;
    logic [AW-1:0]               m_addr_reg;
    logic [gbb_pkg::PIX_W-1:0]   m_value_reg;
    logic                        m_last_reg;

    logic                        out_free;
    logic                        emit;
    logic                        work_done;
    logic [gbb_pkg::PIX_W-1:0]   pixel;

    assign out_free  = !m_valid_reg || m_ready;
    assign emit      = (cnt_reg != '0) && out_free;
    assign work_done = (cnt_reg == '0) || (emit && (cnt_reg == RW'(1)));
    assign q_pop     = work_done && !q_status.empty;
    assign pixel     = (!mono_reg || bits_reg[7]) ? value_reg : gbb_pkg::PIXEL_CLEAR;

    always_comb begin
        cnt_next = cnt_reg;
        if (q_pop) begin
            cnt_next = q_cmd.count;
        end else if (emit) begin
            cnt_next = cnt_reg - RW'(1);
        end
        m_valid_next = m_valid_reg;
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            addr_reg  <= q_cmd.addr;
            value_reg <= q_cmd.value;
            bits_reg  <= q_cmd.bits;
            mono_reg  <= q_cmd.mono;
        end else if (emit) begin
            addr_reg <= addr_reg + AW'(1);
            bits_reg <= {bits_reg[6:0], 1'b0};
        end
        if (emit) begin
            m_addr_reg  <= addr_reg;
            m_value_reg <= pixel;
            m_last_reg  <= cnt_reg == RW'(1);
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_pixel_address = m_addr_reg;
    assign m_pixel_value   = m_value_reg;
    assign m_last_of_run   = m_last_reg;

endmodule

`default_nettype wire

// ----- dv/pixel_write_checker.sv -----
// checker for the glyph blitter: mirrors registers and raster state, predicts and compares pixel writes
`timescale 1ns / 1ps

module pixel_write_checker #(
    parameter int MAX_DEST_WIDTH  = 2048,
    parameter int MAX_DEST_HEIGHT = 2048,
    parameter int MAX_GLYPH_DIM   = 256
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [gbb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gbb_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic [7:0]                     s_source_byte,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic [gbb_pkg::ADDR_W-1:0]     m_pixel_address,
    input  logic [gbb_pkg::PIX_W-1:0]      m_pixel_value,
    input  logic                           m_last_of_run,
    output int unsigned                    mismatch_count,
    output int unsigned                    writes_pending
);

    typedef struct packed {
        logic [gbb_pkg::ADDR_W-1:0] addr;
        logic [gbb_pkg::PIX_W-1:0]  value;
        logic                       last;
    } pixel_write_t;

    gbb_pkg::cfg_t              regs;
    logic [7:0]                 byte_column;
    logic [7:0]                 glyph_row;
    logic [gbb_pkg::ADDR_W-1:0] row_base;
    pixel_write_t               expected_writes [$];
    int unsigned                errors;

    assign mismatch_count = errors;

    function automatic int unsigned clamp_dim(input int unsigned v);
        if (v == 0) return 1;
        return (v > MAX_GLYPH_DIM) ? MAX_GLYPH_DIM : v;
    endfunction

    task automatic expand_source_byte(input logic [7:0] code);
        int unsigned  w;
        int unsigned  h;
        int unsigned  stride;
        int unsigned  rows;
        int unsigned  dest_row;
        int unsigned  off;
        int unsigned  base;
        int unsigned  alpha;
        int unsigned  n;
        pixel_write_t wr;
        w        = (regs.dest_width > MAX_DEST_WIDTH) ? MAX_DEST_WIDTH : regs.dest_width;
        h        = (regs.dest_height > MAX_DEST_HEIGHT) ? MAX_DEST_HEIGHT : regs.dest_height;
        stride   = clamp_dim(regs.source_row_bytes);
        rows     = clamp_dim(regs.source_rows);
        dest_row = int'(regs.origin_y) + int'(glyph_row);
        n        = 0;
        if (byte_column == 0 && glyph_row == 0) begin
            base     = int'(regs.origin_y) * w + int'(regs.origin_x);
            row_base = base[gbb_pkg::ADDR_W-1:0];
        end
        if (dest_row < h) begin
            if (regs.mono_mode) begin
                for (int b = 0; b < 8; b++) begin
                    off = int'(byte_column) * 8 + b;
                    if (int'(regs.origin_x) + off < w) begin
                        base     = int'(row_base) + off;
                        wr.addr  = base[gbb_pkg::ADDR_W-1:0];
                        wr.value = code[7-b] ? regs.glyph_color : gbb_pkg::PIXEL_CLEAR;
                        wr.last  = 1'b0;
                        expected_writes.push_back(wr);
                        n++;
                    end
                end
            end else if (code != 8'h00 && int'(regs.origin_x) + int'(byte_column) < w) begin
                alpha    = (int'(code) * 15) / 255;
                base     = int'(row_base) + int'(byte_column);
                wr.addr  = base[gbb_pkg::ADDR_W-1:0];
                wr.value = (regs.glyph_color & gbb_pkg::COLOR_RGB_MASK) |
                           gbb_pkg::PIX_W'(alpha[3:0]);
                wr.last  = 1'b0;
                expected_writes.push_back(wr);
                n++;
            end
        end
        if (n > 0)
            expected_writes[expected_writes.size()-1].last = 1'b1;

        if (int'(byte_column) + 1 >= stride) begin
            byte_column = '0;
            base        = int'(row_base) + w;
            row_base    = base[gbb_pkg::ADDR_W-1:0];
            if (int'(glyph_row) + 1 >= rows)
                glyph_row = '0;
            else
                glyph_row = glyph_row + 8'd1;
        end else begin
            byte_column = byte_column + 8'd1;
        end
    endtask

    always @(posedge aclk) begin
        pixel_write_t got;
        if (!aresetn) begin
            regs        = gbb_pkg::CFG_RESET;
            byte_column = '0;
            glyph_row   = '0;
            row_base    = '0;
            expected_writes.delete();
            errors         = 0;
            writes_pending <= 0;
        end else begin
            if (cfg_we) begin
                case (gbb_pkg::cfg_index_t'(cfg_index))
                    gbb_pkg::CFG_ORIGIN_X:         regs.origin_x         = cfg_wdata[10:0];
                    gbb_pkg::CFG_ORIGIN_Y:         regs.origin_y         = cfg_wdata[10:0];
                    gbb_pkg::CFG_DEST_WIDTH:       regs.dest_width       = cfg_wdata[11:0];
                    gbb_pkg::CFG_DEST_HEIGHT:      regs.dest_height      = cfg_wdata[11:0];
                    gbb_pkg::CFG_SOURCE_ROW_BYTES: regs.source_row_bytes = cfg_wdata[8:0];
                    gbb_pkg::CFG_SOURCE_ROWS:      regs.source_rows      = cfg_wdata[8:0];
                    gbb_pkg::CFG_MONO_MODE:        regs.mono_mode        = cfg_wdata[0];
                    gbb_pkg::CFG_GLYPH_COLOR:      regs.glyph_color      = cfg_wdata[15:0];
                    default: ;
                endcase
            end
            // result side first: a write never belongs to a byte accepted on the same edge
            if (m_valid && m_ready) begin
                if (expected_writes.size() == 0) begin
                    $error("unexpected pixel write: pixel_address %0h pixel_value %04h",
                           m_pixel_address, m_pixel_value);
                    errors = errors + 1;
                end else begin
                    got = expected_writes.pop_front();
                    if (m_pixel_address !== got.addr) begin
                        $error("pixel_address: expected %0h, actual %0h",
                               got.addr, m_pixel_address);
                        errors = errors + 1;
                    end
                    if (m_pixel_value !== got.value) begin
                        $error("pixel_value: expected %04h, actual %04h",
                               got.value, m_pixel_value);
                        errors = errors + 1;
                    end
                    if (m_last_of_run !== got.last) begin
                        $error("last_of_run: expected %0b, actual %0b",
                               got.last, m_last_of_run);
                        errors = errors + 1;
                    end
                end
            end
            if (s_valid && s_ready)
                expand_source_byte(s_source_byte);
            writes_pending <= expected_writes.size();
        end
    end

endmodule

// ----- dv/tb_glyph_bitmap_to_rgba4444_blit.sv -----
// testbench top for the glyph blitter: register setup, byte stimulus, result stalls and verdict
`timescale 1ns / 1ps

module tb_glyph_bitmap_to_rgba4444_blit;

    localparam int SETTLE_CYCLES = 24;
    localparam int LONG_HOLD     = 300;
    localparam int RANDOM_ITEMS  = 80;

    logic                           aclk;
    logic                           aresetn;
    logic                           cfg_we;
    logic [gbb_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [gbb_pkg::CFG_DATA_W-1:0] cfg_wdata;
    logic                           s_valid;
    logic                           s_ready;
    logic [7:0]                     s_source_byte;
    logic                           m_valid;
    logic                           m_ready;
    logic [gbb_pkg::ADDR_W-1:0]     m_pixel_address;
    logic [gbb_pkg::PIX_W-1:0]      m_pixel_value;
    logic                           m_last_of_run;
    int unsigned                    mismatch_count;
    int unsigned                    writes_pending;

    int unsigned burst_left;
    int unsigned random_sent;
    bit          flood_on;

    glyph_bitmap_to_rgba4444_blit DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_source_byte   (s_source_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pixel_address (m_pixel_address),
        .m_pixel_value   (m_pixel_value),
        .m_last_of_run   (m_last_of_run)
    );

    pixel_write_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_source_byte   (s_source_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pixel_address (m_pixel_address),
        .m_pixel_value   (m_pixel_value),
        .m_last_of_run   (m_last_of_run),
        .mismatch_count  (mismatch_count),
        .writes_pending  (writes_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

    task automatic put_reg(input logic [gbb_pkg::CFG_IDX_W-1:0]  idx,
                           input logic [gbb_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    task automatic load_settings(input gbb_pkg::cfg_t c);
        logic [gbb_pkg::CFG_IDX_W-1:0] stray_idx;
        stray_idx = gbb_pkg::CFG_IDX_W'(gbb_pkg::CFG_GLYPH_COLOR) +
                    gbb_pkg::CFG_IDX_W'($urandom_range(1, 8));
        put_reg(gbb_pkg::CFG_ORIGIN_X,         gbb_pkg::CFG_DATA_W'(c.origin_x));
        put_reg(gbb_pkg::CFG_ORIGIN_Y,         gbb_pkg::CFG_DATA_W'(c.origin_y));
        put_reg(stray_idx,                     gbb_pkg::CFG_DATA_W'($urandom_range(0, 65535)));
        put_reg(gbb_pkg::CFG_DEST_WIDTH,       gbb_pkg::CFG_DATA_W'(c.dest_width));
        put_reg(gbb_pkg::CFG_DEST_HEIGHT,      gbb_pkg::CFG_DATA_W'(c.dest_height));
        put_reg(gbb_pkg::CFG_SOURCE_ROW_BYTES, gbb_pkg::CFG_DATA_W'(c.source_row_bytes));
        put_reg(gbb_pkg::CFG_SOURCE_ROWS,      gbb_pkg::CFG_DATA_W'(c.source_rows));
        put_reg(gbb_pkg::CFG_MONO_MODE,        gbb_pkg::CFG_DATA_W'(c.mono_mode));
        put_reg(gbb_pkg::CFG_GLYPH_COLOR,      c.glyph_color);
        cfg_we <= 1'b0;
    endtask

    // one transaction on the byte channel, then maybe a gap
    task automatic send_byte(input logic [7:0] code);
        s_valid       <= 1'b1;
        s_source_byte <= code;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 50)
                                                     : $urandom_range(0, 8);
        end else begin
            burst_left = burst_left - 1;
        end
    endtask

    task automatic drain_and_settle;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (writes_pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic send_random_bytes(input bit mono, input int unsigned count);
        for (int i = 0; i < count; i++) begin
            if (!mono && $urandom_range(0, 3) == 0)
                send_byte(8'h00);
            else
                send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    function automatic int unsigned edge_pick(input int unsigned maxv);
        case ($urandom_range(0, 4))
            0:       return 0;
            1:       return maxv;
            default: return $urandom_range(0, maxv);
        endcase
    endfunction

    function automatic gbb_pkg::cfg_t pick_settings(input bit wild);
        gbb_pkg::cfg_t c;
        int unsigned   dw;
        int unsigned   dh;
        if (wild) begin
            c.origin_x         = 11'(edge_pick(2047));
            c.origin_y         = 11'(edge_pick(2047));
            c.dest_width       = 12'(edge_pick(4095));
            c.dest_height      = 12'(edge_pick(4095));
            c.source_row_bytes = 9'(edge_pick(511));
            c.source_rows      = 9'(edge_pick(511));
        end else begin
            dw = $urandom_range(0, 1) ? $urandom_range(1, 64) : $urandom_range(1, 2048);
            dh = $urandom_range(0, 1) ? $urandom_range(1, 64) : $urandom_range(1, 2048);
            c.dest_width  = 12'(dw);
            c.dest_height = 12'(dh);
            c.origin_x = 11'((dw > 24 && $urandom_range(0, 1)) ? dw - $urandom_range(1, 24)
                                                               : $urandom_range(0, dw - 1));
            c.origin_y = 11'((dh > 4 && $urandom_range(0, 2) == 0) ? dh - $urandom_range(1, 4)
                                                                   : $urandom_range(0, dh - 1));
            c.source_row_bytes = 9'($urandom_range(1, 6));
            c.source_rows      = 9'($urandom_range(1, 4));
        end
        c.mono_mode   = 1'($urandom_range(0, 1));
        c.glyph_color = 16'($urandom_range(0, 65535));
        return c;
    endfunction

    // receiver stall patterns, plus one long hold-off during the flood phase
    initial begin : result_sink
        int unsigned pattern;
        int unsigned span;
        bit          held;
        m_ready = 1'b0;
        held    = 1'b0;
        pattern = 0;
        span    = 0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (flood_on && !held) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end
            if (span == 0) begin
                pattern = $urandom_range(0, 3);
                span    = $urandom_range(5, 60);
            end
            case (pattern)
                0:       m_ready <= 1'b1;
                1:       m_ready <= ($urandom_range(0, 3) != 0);
                2:       m_ready <= 1'($urandom_range(0, 1));
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
            span = span - 1;
            @(posedge aclk);
        end
    end

    initial begin : stimulus
        gbb_pkg::cfg_t c;
        int unsigned   phase;
        int unsigned   count;
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        s_valid       = 1'b0;
        s_source_byte = 8'h00;
        burst_left    = 0;
        random_sent   = 0;
        flood_on      = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // register values straight out of reset
        send_byte(8'hFF); send_byte(8'h00);
        drain_and_settle();

        // gray coverage extremes and glyph wrap, left mid glyph
        c = gbb_pkg::CFG_RESET;
        c.glyph_color      = 16'hABCD;
        c.source_row_bytes = 9'd3;
        c.source_rows      = 9'd2;
        load_settings(c);
        send_byte(8'h00); send_byte(8'hFF); send_byte(8'h01);
        send_byte(8'h10); send_byte(8'h11); send_byte(8'h80);
        send_byte(8'h7F); send_byte(8'hFE); send_byte(8'h22);
        drain_and_settle();

        // mono with per-pixel clipping at the right edge, settings changed mid glyph
        c = gbb_pkg::CFG_RESET;
        c.origin_x         = 11'd2040;
        c.dest_width       = 12'd2046;
        c.source_row_bytes = 9'd2;
        c.source_rows      = 9'd2;
        c.mono_mode        = 1'b1;
        c.glyph_color      = 16'h1234;
        load_settings(c);
        send_byte(8'hFF); send_byte(8'h00); send_byte(8'hA5);
        send_byte(8'h5A); send_byte(8'h80); send_byte(8'h01);
        drain_and_settle();

        // zero destination, zero stride and zero rows
        c = gbb_pkg::CFG_RESET;
        c.dest_width       = 12'd0;
        c.dest_height      = 12'd0;
        c.source_row_bytes = 9'd0;
        c.source_rows      = 9'd0;
        c.glyph_color      = 16'hFFFF;
        load_settings(c);
        send_byte(8'hFF); send_byte(8'h33); send_byte(8'h01);
        drain_and_settle();

        // oversized destination, origin at the far corner
        c = gbb_pkg::CFG_RESET;
        c.origin_x    = 11'd2047;
        c.origin_y    = 11'd2047;
        c.dest_width  = 12'd4095;
        c.dest_height = 12'd4095;
        c.mono_mode   = 1'b1;
        c.glyph_color = 16'hFFFF;
        load_settings(c);
        send_byte(8'hFF); send_byte(8'h81); send_byte(8'h7E);
        drain_and_settle();

        phase = 0;
        while (random_sent < RANDOM_ITEMS) begin
            if (phase == 3) begin
                c = pick_settings(1'b0);
                c.origin_x   = 11'd0;
                c.dest_width = 12'd2048;
                c.mono_mode  = 1'b1;
                count        = 30;
                flood_on     = 1'b1;
            end else begin
                c     = pick_settings($urandom_range(0, 3) == 0);
                count = $urandom_range(8, 24);
            end
            load_settings(c);
            send_random_bytes(c.mono_mode, count);
            flood_on    = 1'b0;
            random_sent = random_sent + count;
            drain_and_settle();
            phase++;
        end

        if (mismatch_count == 0 && writes_pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
